### hw/rtl/tdps_pkg.sv
package tdps_pkg;

    localparam int TABLE_PRIMES = 120;
    localparam int CNT_W        = 32;
    localparam int PRIME_W      = 10;
    localparam int IDX_W        = 7;

    // register indexes on the configuration port
    localparam logic REG_PRIME_COUNT    = 1'b0;
    localparam logic REG_EXIT_THRESHOLD = 1'b1;

    // transaction modes
    localparam logic MODE_PROCESS = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    localparam logic [PRIME_W-1:0] PRIMES [TABLE_PRIMES] = '{
        10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,  10'd23,
        10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,  10'd59,
        10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,  10'd97,
        10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131, 10'd137,
        10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173, 10'd179,
        10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223, 10'd227,
        10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269,
        10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313,
        10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367,
        10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419,
        10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457, 10'd461,
        10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503, 10'd509,
        10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569, 10'd571,
        10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613, 10'd617,
        10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659, 10'd661
    };

    typedef struct packed {
        logic              mode;
        logic [60:0]       n_value;
        logic [IDX_W-1:0]  prime_index;
    } t_in;

    typedef struct packed {
        logic [31:0] hit_count;
        logic [31:0] stop_a;
        logic [62:0] stop_candidate;
        logic [31:0] candidates_tried;
        logic        found_unfiltered;
        logic [31:0] candidate_sum;
        logic [31:0] filtered_sum;
        logic [31:0] total_passed;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SQRT, S_ADJ, S_SQ, S_DIFF, S_DIV, S_CHK,
        S_HRD, S_HWR, S_PASS, S_NEXT, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic adj;
        logic sq;
        logic diff;
        logic div_step;
        logic prime_next;
        logic mem_rd;
        logic mem_wr;
        logic pass;
        logic next_a;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic sqrt_last;
        logic cand_ok;
        logic limit_zero;
        logic chunk_last;
        logic rem_zero;
        logic prime_last;
        logic above_thr;
        logic a_le1;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [PRIME_W-1:0] prime_at(logic [IDX_W-1:0] idx);
        return (idx < IDX_W'(TABLE_PRIMES)) ? PRIMES[idx] : '0;
    endfunction

endpackage

### hw/rtl/tdps_ctrl.sv
module tdps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tdps_pkg::t_sts  i_sts,
    output tdps_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    tdps_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.mode == tdps_pkg::MODE_READ) ?
                              tdps_pkg::S_RD : tdps_pkg::S_SQRT;
                end
            end
            tdps_pkg::S_RD:   n_state = tdps_pkg::S_OUT;
            tdps_pkg::S_SQRT: begin
                if (i_sts.sqrt_last) begin
                    n_state = tdps_pkg::S_ADJ;
                end
            end
            tdps_pkg::S_ADJ:  n_state = tdps_pkg::S_SQ;
            tdps_pkg::S_SQ:   n_state = tdps_pkg::S_DIFF;
            tdps_pkg::S_DIFF: begin
                if (!i_sts.cand_ok) begin
                    n_state = tdps_pkg::S_NEXT;
                end else if (i_sts.limit_zero) begin
                    n_state = tdps_pkg::S_PASS;
                end else begin
                    n_state = tdps_pkg::S_DIV;
                end
            end
            tdps_pkg::S_DIV: begin
                if (i_sts.chunk_last) begin
                    n_state = tdps_pkg::S_CHK;
                end
            end
            tdps_pkg::S_CHK: begin
                if (i_sts.rem_zero) begin
                    n_state = tdps_pkg::S_HRD;
                end else if (i_sts.prime_last) begin
                    n_state = tdps_pkg::S_PASS;
                end else begin
                    n_state = tdps_pkg::S_DIV;
                end
            end
            tdps_pkg::S_HRD:  n_state = tdps_pkg::S_HWR;
            tdps_pkg::S_HWR:  n_state = tdps_pkg::S_NEXT;
            tdps_pkg::S_PASS: begin
                n_state = i_sts.above_thr ? tdps_pkg::S_OUT : tdps_pkg::S_NEXT;
            end
            tdps_pkg::S_NEXT: begin
                n_state = i_sts.a_le1 ? tdps_pkg::S_OUT : tdps_pkg::S_SQ;
            end
            tdps_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = tdps_pkg::S_IDLE;
                end
            end
            default: n_state = tdps_pkg::S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            tdps_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            tdps_pkg::S_RD:   o_cmd.mem_rd    = 1'b1;
            tdps_pkg::S_SQRT: o_cmd.sqrt_step = 1'b1;
            tdps_pkg::S_ADJ:  o_cmd.adj       = 1'b1;
            tdps_pkg::S_SQ:   o_cmd.sq        = 1'b1;
            tdps_pkg::S_DIFF: o_cmd.diff      = 1'b1;
            tdps_pkg::S_DIV:  o_cmd.div_step  = 1'b1;
            tdps_pkg::S_CHK:  o_cmd.prime_next = !i_sts.rem_zero && !i_sts.prime_last;
            tdps_pkg::S_HRD:  o_cmd.mem_rd    = 1'b1;
            tdps_pkg::S_HWR:  o_cmd.mem_wr    = 1'b1;
            tdps_pkg::S_PASS: o_cmd.pass      = 1'b1;
            tdps_pkg::S_NEXT: o_cmd.next_a    = !i_sts.a_le1;
            tdps_pkg::S_OUT:  o_cmd.out_load  = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### hw/rtl/tdps_dp.sv
module tdps_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tdps_pkg::t_cmd               i_cmd,
    output tdps_pkg::t_sts               o_sts,
    input  tdps_pkg::t_in                i_in_data,
    input  logic [tdps_pkg::IDX_W-1:0]   i_prime_count,
    input  logic [15:0]                  i_exit_threshold,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tdps_pkg::t_out               o_out_data
);

    logic                               r_mode;
    logic [tdps_pkg::IDX_W-1:0]         r_pidx;
    logic [tdps_pkg::IDX_W-1:0]         r_limit;
    logic [63:0]                        r_n_big;
    logic [63:0]                        r_x;
    logic [31:0]                        r_rem;
    logic [31:0]                        r_root;
    logic [4:0]                         r_scnt;
    logic [31:0]                        r_a;
    logic [63:0]                        r_sq;
    logic [62:0]                        r_c;
    logic [63:0]                        r_shift;
    logic [2:0]                         r_chunk;
    logic [tdps_pkg::PRIME_W-1:0]       r_res;
    logic [tdps_pkg::IDX_W-1:0]         r_j;
    logic [31:0]                        r_sa;
    logic [62:0]                        r_sc;
    logic [tdps_pkg::CNT_W-1:0]         r_tried;
    logic                               r_found;
    logic [tdps_pkg::CNT_W-1:0]         r_tot_cand;
    logic [tdps_pkg::CNT_W-1:0]         r_tot_filt;
    logic [tdps_pkg::CNT_W-1:0]         r_tot_pass;
    logic [tdps_pkg::CNT_W-1:0]         r_mem [tdps_pkg::TABLE_PRIMES];
    logic [tdps_pkg::TABLE_PRIMES-1:0]  r_hv;
    logic [tdps_pkg::CNT_W-1:0]         r_rd_data;
    logic                               r_rd_ok;
    logic                               r_out_valid;
    tdps_pkg::t_out                     r_out;

    logic [33:0]                        rem_sh;
    logic [33:0]                        trial;
    logic [63:0]                        diff;
    logic [tdps_pkg::PRIME_W-1:0]       p_cur;
    logic [tdps_pkg::PRIME_W-1:0]       res_step;
    logic [tdps_pkg::PRIME_W:0]         res_tmp;
    logic [tdps_pkg::IDX_W-1:0]         rd_addr;
    logic                               rd_in_range;
    logic [tdps_pkg::CNT_W-1:0]         hit_next;

    // square root digit step
    assign rem_sh = {r_rem, r_x[63:62]};
    assign trial  = {r_root, 2'b01};

    // candidate from the current square
    assign diff  = r_n_big - r_sq;
    assign p_cur = tdps_pkg::prime_at(r_j);

    // eight remainder bits per cycle
    always_comb begin
        res_step = r_res;
        res_tmp  = '0;
        for (int k = 0; k < 8; k++) begin
            res_tmp = {res_step, r_shift[63-k]};
            if (res_tmp >= {1'b0, p_cur}) begin
                res_tmp = res_tmp - {1'b0, p_cur};
            end
            res_step = res_tmp[tdps_pkg::PRIME_W-1:0];
        end
    end

    assign rd_addr     = (r_mode == tdps_pkg::MODE_READ) ? r_pidx : r_j;
    assign rd_in_range = rd_addr < tdps_pkg::IDX_W'(tdps_pkg::TABLE_PRIMES);
    assign hit_next    = r_rd_ok ? tdps_pkg::sat_inc(r_rd_data) : tdps_pkg::CNT_W'(1);

    // status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.mode       = i_in_data.mode;
        o_sts.sqrt_last  = &r_scnt;
        o_sts.cand_ok    = |diff[63:2];
        o_sts.limit_zero = r_limit == '0;
        o_sts.chunk_last = &r_chunk;
        o_sts.rem_zero   = r_res == '0;
        o_sts.prime_last = r_j == r_limit - 1'b1;
        o_sts.above_thr  = r_c > {47'd0, i_exit_threshold};
        o_sts.a_le1      = r_a <= 32'd1;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // per item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in_data.mode;
            r_pidx  <= i_in_data.prime_index;
            r_limit <= (i_prime_count > tdps_pkg::IDX_W'(tdps_pkg::TABLE_PRIMES)) ?
                       tdps_pkg::IDX_W'(tdps_pkg::TABLE_PRIMES) : i_prime_count;
            r_n_big <= {i_in_data.n_value, 3'b011};
            r_x     <= {i_in_data.n_value, 3'b011};
            r_rem   <= '0;
            r_root  <= '0;
            r_scnt  <= '0;
            r_sa    <= '0;
            r_sc    <= '0;
            r_tried <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.sqrt_step) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_scnt <= r_scnt + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= 32'(rem_sh - trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[31:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
        if (i_cmd.adj) begin
            r_a <= r_root[0] ? r_root : r_root - 1'b1;
        end
        if (i_cmd.sq) begin
            r_sq <= r_a * r_a;
        end
        if (i_cmd.diff) begin
            r_c     <= diff[63:1];
            r_shift <= {1'b0, diff[63:1]};
            r_chunk <= '0;
            r_res   <= '0;
            r_j     <= '0;
            if (|diff[63:2]) begin
                r_tried <= tdps_pkg::sat_inc(r_tried);
                r_sc    <= diff[63:1];
            end
        end
        if (i_cmd.div_step) begin
            r_res   <= res_step;
            r_shift <= {r_shift[55:0], 8'd0};
            r_chunk <= r_chunk + 1'b1;
        end
        if (i_cmd.prime_next) begin
            r_j     <= r_j + 1'b1;
            r_res   <= '0;
            r_shift <= {1'b0, r_c};
            r_chunk <= '0;
        end
        if (i_cmd.pass && o_sts.above_thr) begin
            r_found <= 1'b1;
            r_sa    <= r_a;
        end
        if (i_cmd.next_a) begin
            r_a <= r_a - 32'd2;
        end
    end

    // running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_cand <= '0;
            r_tot_filt <= '0;
            r_tot_pass <= '0;
        end else begin
            if (i_cmd.diff && (|diff[63:2])) begin
                r_tot_cand <= tdps_pkg::sat_inc(r_tot_cand);
            end
            if (i_cmd.mem_wr) begin
                r_tot_filt <= tdps_pkg::sat_inc(r_tot_filt);
            end
            if (i_cmd.pass) begin
                r_tot_pass <= tdps_pkg::sat_inc(r_tot_pass);
            end
        end
    end

    // hit counter memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd && rd_in_range) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.mem_wr) begin
            r_mem[r_j] <= hit_next;
        end
    end

    // entry valid flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.mem_rd) begin
                r_rd_ok <= rd_in_range && r_hv[rd_addr];
            end
            if (i_cmd.mem_wr) begin
                r_hv[r_j] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.hit_count        <= ((r_mode == tdps_pkg::MODE_READ) && r_rd_ok) ?
                                      r_rd_data : '0;
            r_out.stop_a           <= r_sa;
            r_out.stop_candidate   <= r_sc;
            r_out.candidates_tried <= r_tried;
            r_out.found_unfiltered <= r_found;
            r_out.candidate_sum    <= r_tot_cand;
            r_out.filtered_sum     <= r_tot_filt;
            r_out.total_passed     <= r_tot_pass;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the walk only ever squares odd values of a
    a_odd_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sq |-> r_a[0])
        else $error("even a reached the squaring step");

    // remainder stays reduced by the current prime
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_res < p_cur))
        else $error("trial remainder not reduced");

    // hit counter updates stay within the table
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr |-> (r_j < tdps_pkg::IDX_W'(tdps_pkg::TABLE_PRIMES)))
        else $error("hit counter write outside the table");

    // a result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");

endmodule

### hw/rtl/trial_division_profile_search.sv
// Trial-division profile search over candidates of N = 8n + 3.
// Input channel (i_in_valid / o_in_stall) carries one transaction: mode 0
// processes n_value, mode 1 reads the hit counter at prime_index.
// Output channel (o_out_valid / i_out_stall) returns one result per input
// transaction, held in an output register until taken.
// Registers on the APB-style port: prime_count at 0x0, exit_threshold at 0x4.
// Steps: a read accepts the transaction, reads the hit counter memory and
// loads the output register. A process transaction is accepted, takes the
// square root and sets up the first odd a; per odd a it squares a, forms
// the candidate, divides it by each prime tried and updates the hit counter
// on a hit, and last loads the output register; the shared 8-bit-per-cycle
// remainder unit sets the rate. One transaction is worked on
// at a time; the next is taken once the result sits in the output register.
// Reset at once clears the hit counters (via per-entry valid flags) and
// running totals, and sets prime_count to 120 and exit_threshold to 127.
// When the receiver stalls, the finished result waits and the block
// holds its completed work until the output register frees up.
module trial_division_profile_search (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tdps_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tdps_pkg::t_out  o_out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [tdps_pkg::IDX_W-1:0] r_prime_count;
    logic [15:0]                r_exit_threshold;
    tdps_pkg::t_cmd             cmd;
    tdps_pkg::t_sts             sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_count    <= tdps_pkg::IDX_W'(tdps_pkg::TABLE_PRIMES);
            r_exit_threshold <= 16'd127;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                tdps_pkg::REG_PRIME_COUNT:    r_prime_count    <= pwdata[6:0];
                tdps_pkg::REG_EXIT_THRESHOLD: r_exit_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            tdps_pkg::REG_PRIME_COUNT:    prdata = {25'd0, r_prime_count};
            tdps_pkg::REG_EXIT_THRESHOLD: prdata = {16'd0, r_exit_threshold};
            default:                      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    tdps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tdps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_data        (i_in_data),
        .i_prime_count    (r_prime_count),
        .i_exit_threshold (r_exit_threshold),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_data       (o_out_data)
    );

endmodule
